// File: rtl/orot_pkg.sv
// Package: shared types, constants, tables and the multiply sequence of the frame rotator.
package orot_pkg;

  // Fixed-point format and angle resolution
  localparam int FRAC_BITS   = 30;
  localparam int ANGLE_BITS  = 32;
  localparam int QBITS       = FRAC_BITS + 1;
  localparam int ROT_SH      = 30 - FRAC_BITS;
  localparam int SQRT_STEPS  = 32;
  localparam int CRD_STEPS   = 30;

  localparam logic signed [31:0] ONE        = 32'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [63:0] RND_HALF   = 64'((64'sd1 <<< FRAC_BITS) >>> 1);
  localparam logic signed [33:0] CRD_HALF   = 34'((34'sd1 <<< ROT_SH) >>> 1);
  localparam logic [31:0]        ANGLE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);
  localparam logic signed [33:0] CRD_GAIN   = 34'sd652032874;
  localparam logic [23:0]        NORM_MIN   = 24'h40_0000;
  localparam logic [31:0]        QUARTER    = 32'h4000_0000;
  localparam logic [31:0]        HALF_TURN  = 32'h8000_0000;

  // Multiply program landmarks
  localparam logic [5:0] PC_SQ_LAST   = 6'd2;
  localparam logic [5:0] PC_ROT_FIRST = 6'd3;
  localparam logic [5:0] PC_LAST      = 6'd50;

  typedef enum logic [1:0] {
    OP_ROT      = 2'd0,
    OP_SAVE_ROT = 2'd1,
    OP_RESTORE  = 2'd2,
    OP_IDENT    = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [23:0] axis_x;
    logic signed [23:0] axis_y;
    logic signed [23:0] axis_z;
    logic [31:0]        turn_angle;
  } in_t;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
    logic signed [31:0] third_z;
    logic               axis_error;
  } out_t;

  // Multiplier operand sources
  typedef enum logic [3:0] {
    SRC_F, SRC_NF, SRC_U, SRC_W, SRC_V, SRC_T, SRC_C, SRC_S, SRC_OMC, SRC_D
  } src_e;

  typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_e;

  typedef enum logic [3:0] {
    WB_NONE, WB_N2, WB_D, WB_W, WB_T, WB_SUMLD, WB_SUMADD, WB_NF, WB_NFX
  } wb_e;

  typedef struct packed {
    src_e       a_sel;
    logic [3:0] a_idx;
    src_e       b_sel;
    logic [3:0] b_idx;
    acc_e       acc;
    wb_e        wb;
    logic [3:0] wb_idx;
  } uop_t;

  typedef enum logic [2:0] {MP_IDLE, MP_LDA, MP_MUL, MP_ACC, MP_WB} mac_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_NORM, ST_LDA, ST_MUL, ST_ACC, ST_WB, ST_SQRT,
    ST_DIVI, ST_DIV, ST_DIVW, ST_CRDI, ST_CRD, ST_CRDW, ST_COMMIT, ST_DONE
  } st_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch;
    logic       save;
    logic       restore;
    logic       identity;
    logic       set_err;
    logic       norm_step;
    mac_e       mac;
    logic [5:0] pc;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_wr;
    logic [1:0] idx;
    logic       crd_init;
    logic       crd_step;
    logic       crd_wr;
    logic [4:0] k;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic zero_axis;
    logic norm_ok;
  } sts_t;

  // CORDIC arctangent table in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] k);
    logic [29:0] r;
    unique case (k)
      5'd0:  r = 30'h2000_0000;
      5'd1:  r = 30'h12E4_051E;
      5'd2:  r = 30'h09FB_385B;
      5'd3:  r = 30'h0511_11D4;
      5'd4:  r = 30'h028B_0D43;
      5'd5:  r = 30'h0145_D7E1;
      5'd6:  r = 30'h00A2_F61E;
      5'd7:  r = 30'h0051_7C55;
      5'd8:  r = 30'h0028_BE53;
      5'd9:  r = 30'h0014_5F2F;
      5'd10: r = 30'h000A_2F98;
      5'd11: r = 30'h0005_17CC;
      5'd12: r = 30'h0002_8BE6;
      5'd13: r = 30'h0001_45F3;
      5'd14: r = 30'h0000_A2FA;
      5'd15: r = 30'h0000_517D;
      5'd16: r = 30'h0000_28BE;
      5'd17: r = 30'h0000_145F;
      5'd18: r = 30'h0000_0A30;
      5'd19: r = 30'h0000_0518;
      5'd20: r = 30'h0000_028C;
      5'd21: r = 30'h0000_0146;
      5'd22: r = 30'h0000_00A3;
      5'd23: r = 30'h0000_0051;
      5'd24: r = 30'h0000_0029;
      5'd25: r = 30'h0000_0014;
      5'd26: r = 30'h0000_000A;
      5'd27: r = 30'h0000_0005;
      5'd28: r = 30'h0000_0003;
      5'd29: r = 30'h0000_0001;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

  // Saturate to [-ONE, ONE]
  function automatic logic signed [31:0] clamp_one(input logic signed [35:0] v);
    logic signed [35:0] lim;
    lim = 36'(ONE);
    if (v > lim) return ONE;
    if (v < -lim) return -ONE;
    return v[31:0];
  endfunction

  // Identity frame entry
  function automatic logic signed [31:0] ident(input logic [3:0] k);
    return (k == 4'd0 || k == 4'd4 || k == 4'd8) ? ONE : 32'sd0;
  endfunction

  function automatic uop_t mk(input src_e a, input logic [3:0] ai, input src_e b,
                              input logic [3:0] bi, input acc_e ac, input wb_e wb,
                              input logic [3:0] wi);
    uop_t u;
    u.a_sel = a; u.a_idx = ai; u.b_sel = b; u.b_idx = bi;
    u.acc = ac; u.wb = wb; u.wb_idx = wi;
    return u;
  endfunction

  // Multiply program: axis length, Rodrigues on first and second vector, cross product
  function automatic uop_t uop_rom(input logic [5:0] pc);
    uop_t r;
    unique case (pc)
      6'd0:  r = mk(SRC_V, 4'd0, SRC_V, 4'd0, ACC_LOAD, WB_NONE, 4'd0);
      6'd1:  r = mk(SRC_V, 4'd1, SRC_V, 4'd1, ACC_ADD, WB_NONE, 4'd0);
      6'd2:  r = mk(SRC_V, 4'd2, SRC_V, 4'd2, ACC_ADD, WB_N2, 4'd0);
      // first vector
      6'd3:  r = mk(SRC_F, 4'd0, SRC_U, 4'd0, ACC_LOAD, WB_NONE, 4'd0);
      6'd4:  r = mk(SRC_F, 4'd1, SRC_U, 4'd1, ACC_ADD, WB_NONE, 4'd0);
      6'd5:  r = mk(SRC_F, 4'd2, SRC_U, 4'd2, ACC_ADD, WB_D, 4'd0);
      6'd6:  r = mk(SRC_U, 4'd1, SRC_F, 4'd2, ACC_LOAD, WB_NONE, 4'd0);
      6'd7:  r = mk(SRC_U, 4'd2, SRC_F, 4'd1, ACC_SUB, WB_W, 4'd0);
      6'd8:  r = mk(SRC_U, 4'd2, SRC_F, 4'd0, ACC_LOAD, WB_NONE, 4'd0);
      6'd9:  r = mk(SRC_U, 4'd0, SRC_F, 4'd2, ACC_SUB, WB_W, 4'd1);
      6'd10: r = mk(SRC_U, 4'd0, SRC_F, 4'd1, ACC_LOAD, WB_NONE, 4'd0);
      6'd11: r = mk(SRC_U, 4'd1, SRC_F, 4'd0, ACC_SUB, WB_W, 4'd2);
      6'd12: r = mk(SRC_F, 4'd0, SRC_C, 4'd0, ACC_LOAD, WB_SUMLD, 4'd0);
      6'd13: r = mk(SRC_U, 4'd0, SRC_D, 4'd0, ACC_LOAD, WB_T, 4'd0);
      6'd14: r = mk(SRC_T, 4'd0, SRC_OMC, 4'd0, ACC_LOAD, WB_SUMADD, 4'd0);
      6'd15: r = mk(SRC_W, 4'd0, SRC_S, 4'd0, ACC_LOAD, WB_NF, 4'd0);
      6'd16: r = mk(SRC_F, 4'd1, SRC_C, 4'd0, ACC_LOAD, WB_SUMLD, 4'd0);
      6'd17: r = mk(SRC_U, 4'd1, SRC_D, 4'd0, ACC_LOAD, WB_T, 4'd0);
      6'd18: r = mk(SRC_T, 4'd0, SRC_OMC, 4'd0, ACC_LOAD, WB_SUMADD, 4'd0);
      6'd19: r = mk(SRC_W, 4'd1, SRC_S, 4'd0, ACC_LOAD, WB_NF, 4'd1);
      6'd20: r = mk(SRC_F, 4'd2, SRC_C, 4'd0, ACC_LOAD, WB_SUMLD, 4'd0);
      6'd21: r = mk(SRC_U, 4'd2, SRC_D, 4'd0, ACC_LOAD, WB_T, 4'd0);
      6'd22: r = mk(SRC_T, 4'd0, SRC_OMC, 4'd0, ACC_LOAD, WB_SUMADD, 4'd0);
      6'd23: r = mk(SRC_W, 4'd2, SRC_S, 4'd0, ACC_LOAD, WB_NF, 4'd2);
      // second vector
      6'd24: r = mk(SRC_F, 4'd3, SRC_U, 4'd0, ACC_LOAD, WB_NONE, 4'd0);
      6'd25: r = mk(SRC_F, 4'd4, SRC_U, 4'd1, ACC_ADD, WB_NONE, 4'd0);
      6'd26: r = mk(SRC_F, 4'd5, SRC_U, 4'd2, ACC_ADD, WB_D, 4'd0);
      6'd27: r = mk(SRC_U, 4'd1, SRC_F, 4'd5, ACC_LOAD, WB_NONE, 4'd0);
      6'd28: r = mk(SRC_U, 4'd2, SRC_F, 4'd4, ACC_SUB, WB_W, 4'd0);
      6'd29: r = mk(SRC_U, 4'd2, SRC_F, 4'd3, ACC_LOAD, WB_NONE, 4'd0);
      6'd30: r = mk(SRC_U, 4'd0, SRC_F, 4'd5, ACC_SUB, WB_W, 4'd1);
      6'd31: r = mk(SRC_U, 4'd0, SRC_F, 4'd4, ACC_LOAD, WB_NONE, 4'd0);
      6'd32: r = mk(SRC_U, 4'd1, SRC_F, 4'd3, ACC_SUB, WB_W, 4'd2);
      6'd33: r = mk(SRC_F, 4'd3, SRC_C, 4'd0, ACC_LOAD, WB_SUMLD, 4'd0);
      6'd34: r = mk(SRC_U, 4'd0, SRC_D, 4'd0, ACC_LOAD, WB_T, 4'd0);
      6'd35: r = mk(SRC_T, 4'd0, SRC_OMC, 4'd0, ACC_LOAD, WB_SUMADD, 4'd0);
      6'd36: r = mk(SRC_W, 4'd0, SRC_S, 4'd0, ACC_LOAD, WB_NF, 4'd3);
      6'd37: r = mk(SRC_F, 4'd4, SRC_C, 4'd0, ACC_LOAD, WB_SUMLD, 4'd0);
      6'd38: r = mk(SRC_U, 4'd1, SRC_D, 4'd0, ACC_LOAD, WB_T, 4'd0);
      6'd39: r = mk(SRC_T, 4'd0, SRC_OMC, 4'd0, ACC_LOAD, WB_SUMADD, 4'd0);
      6'd40: r = mk(SRC_W, 4'd1, SRC_S, 4'd0, ACC_LOAD, WB_NF, 4'd4);
      6'd41: r = mk(SRC_F, 4'd5, SRC_C, 4'd0, ACC_LOAD, WB_SUMLD, 4'd0);
      6'd42: r = mk(SRC_U, 4'd2, SRC_D, 4'd0, ACC_LOAD, WB_T, 4'd0);
      6'd43: r = mk(SRC_T, 4'd0, SRC_OMC, 4'd0, ACC_LOAD, WB_SUMADD, 4'd0);
      6'd44: r = mk(SRC_W, 4'd2, SRC_S, 4'd0, ACC_LOAD, WB_NF, 4'd5);
      // third vector = first x second
      6'd45: r = mk(SRC_NF, 4'd1, SRC_NF, 4'd5, ACC_LOAD, WB_NONE, 4'd0);
      6'd46: r = mk(SRC_NF, 4'd2, SRC_NF, 4'd4, ACC_SUB, WB_NFX, 4'd6);
      6'd47: r = mk(SRC_NF, 4'd2, SRC_NF, 4'd3, ACC_LOAD, WB_NONE, 4'd0);
      6'd48: r = mk(SRC_NF, 4'd0, SRC_NF, 4'd5, ACC_SUB, WB_NFX, 4'd7);
      6'd49: r = mk(SRC_NF, 4'd0, SRC_NF, 4'd4, ACC_LOAD, WB_NONE, 4'd0);
      6'd50: r = mk(SRC_NF, 4'd1, SRC_NF, 4'd3, ACC_SUB, WB_NFX, 4'd8);
      default: r = mk(SRC_F, 4'd0, SRC_F, 4'd0, ACC_LOAD, WB_NONE, 4'd0);
    endcase
    return r;
  endfunction

endpackage

// File: rtl/orientation_frame_rotator_top.sv
// Top level: axis-angle rotation of a stored orientation frame.
//
//  channel  | ports                        | beat taken when
//  ---------+------------------------------+-------------------------------
//  item     | start, busy, item_i          | start high and busy low
//  result   | result_valid_o, result_o     | every cycle result_valid_o is high
//
// Restore and identity beats give their result in the cycle after acceptance; a
// rotate with an all-zero axis passes through the check state before giving it.
// A rotate uses n (0 to 22) normalizing shifts of the axis, a 51-product
// program on the shared 33x33 multiplier (load, multiply, accumulate and, where
// it writes back, writeback states per product), the 32-step square root, three
// 31-step divisions and the 30-step CORDIC. One item is worked at a time.
// Reset loads the identity into the frame and the saved frame. Results cannot
// be held off: result_o is valid only in the strobe cycle.
module orientation_frame_rotator_top import orot_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic result_valid_o,
  output out_t result_o
);

  cmd_t cmd;
  sts_t sts;

  orot_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (item_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (result_valid_o)
  );

  orot_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .item_i (item_i),
    .sts_o  (sts),
    .res_o  (result_o)
  );

endmodule

// File: rtl/orot_dp.sv
// Datapath: frame registers, shared multiplier, square root, divider and CORDIC units.
module orot_dp import orot_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  item_i,
  output sts_t sts_o,
  output out_t res_o
);

  logic signed [31:0] f_q [9];
  logic signed [31:0] sv_q [9];
  logic signed [31:0] nf_q [9];
  logic signed [24:0] v_q [3];
  logic [23:0]        m_q;
  logic [31:0]        ang_q;
  logic signed [31:0] u_q [3];
  logic signed [32:0] w_q [3];
  logic signed [32:0] d_q, t_q, omc_q;
  logic signed [31:0] c_q, s_q;
  logic signed [34:0] sum_q;
  logic signed [32:0] a_q;
  logic signed [65:0] p_q;
  logic signed [63:0] acc_q;
  logic [63:0]        sq_n_q, sq_r_q, sq_b_q;
  logic [32:0]        rem_q;
  logic [QBITS-1:0]   q_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic               err_q;

  uop_t               uop;
  src_e               rd_sel;
  logic [3:0]         rd_idx;
  logic signed [32:0] rd;
  logic signed [63:0] rnd64;
  logic signed [33:0] rnd;
  logic [23:0]        av [3];
  logic [23:0]        m_in;
  logic [63:0]        sq_t;
  logic [31:0]        len;
  logic [32:0]        div_t;
  logic [24:0]        dv_abs;
  logic signed [35:0] q_s;
  logic [31:0]        ph, ph_f;
  logic               ph_flip;
  logic signed [33:0] xs, ys, atn, xf, yf, xr, yr;
  logic signed [31:0] c_new, s_new;

  // Operand read port and microcode decode
  assign uop    = uop_rom(cmd_i.pc);
  assign rd_sel = (cmd_i.mac == MP_LDA) ? uop.a_sel : uop.b_sel;
  assign rd_idx = (cmd_i.mac == MP_LDA) ? uop.a_idx : uop.b_idx;

  always_comb begin
    unique case (rd_sel)
      SRC_F:   rd = 33'(f_q[rd_idx]);
      SRC_NF:  rd = 33'(nf_q[rd_idx]);
      SRC_U:   rd = 33'(u_q[rd_idx[1:0]]);
      SRC_W:   rd = w_q[rd_idx[1:0]];
      SRC_V:   rd = 33'(v_q[rd_idx[1:0]]);
      SRC_T:   rd = t_q;
      SRC_C:   rd = 33'(c_q);
      SRC_S:   rd = 33'(s_q);
      SRC_OMC: rd = omc_q;
      SRC_D:   rd = d_q;
      default: rd = '0;
    endcase
  end

  // Rounded accumulator value
  assign rnd64 = (acc_q + RND_HALF) >>> FRAC_BITS;
  assign rnd   = rnd64[33:0];

  // Magnitudes of the incoming axis
  always_comb begin
    logic signed [24:0] e;
    for (int i = 0; i < 3; i++) begin
      unique case (i)
        0:       e = 25'(item_i.axis_x);
        1:       e = 25'(item_i.axis_y);
        default: e = 25'(item_i.axis_z);
      endcase
      av[i] = e[24] ? 24'(-e) : e[23:0];
    end
    m_in = av[0];
    if (av[1] > m_in) m_in = av[1];
    if (av[2] > m_in) m_in = av[2];
  end

  // Square root and divider step terms
  assign sq_t   = sq_r_q + sq_b_q;
  assign len    = sq_r_q[31:0];
  assign div_t  = {rem_q[31:0], 1'b0};
  assign dv_abs = v_q[cmd_i.idx][24] ? 25'(-v_q[cmd_i.idx]) : 25'(v_q[cmd_i.idx]);
  // signed quotient, saturated to one on write
  assign q_s    = v_q[cmd_i.idx][24] ? -$signed(36'(q_q)) : $signed(36'(q_q));

  // CORDIC terms
  assign ph      = ang_q & ANGLE_MASK;
  assign ph_flip = (ph + QUARTER) >= HALF_TURN;
  assign ph_f    = ph_flip ? (ph ^ HALF_TURN) : ph;
  assign xs      = cx_q >>> cmd_i.k;
  assign ys      = cy_q >>> cmd_i.k;
  assign atn     = 34'(atan_turn(cmd_i.k));
  assign xf      = flip_q ? -cx_q : cx_q;
  assign yf      = flip_q ? -cy_q : cy_q;
  assign xr      = (xf + CRD_HALF) >>> ROT_SH;
  assign yr      = (yf + CRD_HALF) >>> ROT_SH;
  assign c_new   = clamp_one(36'(xr));
  assign s_new   = clamp_one(36'(yr));

  // Frame state and error flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        f_q[i]  <= ident(4'(i));
        sv_q[i] <= ident(4'(i));
      end
      err_q <= 1'b0;
    end else begin
      if (cmd_i.save) sv_q <= f_q;
      if (cmd_i.restore) begin
        f_q <= sv_q;
      end else if (cmd_i.identity) begin
        for (int i = 0; i < 9; i++) f_q[i] <= ident(4'(i));
      end else if (cmd_i.commit) begin
        f_q <= nf_q;
      end
      if (cmd_i.latch) err_q <= 1'b0;
      else if (cmd_i.set_err) err_q <= 1'b1;
    end
  end

  // Axis capture and normalizing shift
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      v_q[0] <= 25'(item_i.axis_x);
      v_q[1] <= 25'(item_i.axis_y);
      v_q[2] <= 25'(item_i.axis_z);
      m_q    <= m_in;
      ang_q  <= item_i.turn_angle;
    end else if (cmd_i.norm_step) begin
      for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] <<< 1;
      m_q <= m_q << 1;
    end
  end

  // Shared multiply-accumulate with writeback
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.mac)
      MP_LDA: a_q <= rd;
      MP_MUL: p_q <= a_q * rd;
      MP_ACC: begin
        unique case (uop.acc)
          ACC_LOAD: acc_q <= p_q[63:0];
          ACC_ADD:  acc_q <= acc_q + p_q[63:0];
          ACC_SUB:  acc_q <= acc_q - p_q[63:0];
          default:  acc_q <= acc_q;
        endcase
      end
      MP_WB: begin
        unique case (uop.wb)
          WB_D:      d_q <= rnd[32:0];
          WB_W:      w_q[uop.wb_idx[1:0]] <= rnd[32:0];
          WB_T:      t_q <= rnd[32:0];
          WB_SUMLD:  sum_q <= 35'(rnd);
          WB_SUMADD: sum_q <= sum_q + 35'(rnd);
          WB_NF:     nf_q[uop.wb_idx] <= clamp_one(36'(sum_q) + 36'(rnd));
          WB_NFX:    nf_q[uop.wb_idx] <= clamp_one(36'(rnd));
          default:   ;
        endcase
      end
      default: ;
    endcase
  end

  // Bit-serial square root of the scaled squared length
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac == MP_WB && uop.wb == WB_N2) begin
      sq_n_q <= {acc_q[47:0], 16'd0};
      sq_r_q <= '0;
      sq_b_q <= 64'd1 << 62;
    end else if (cmd_i.sqrt_step) begin
      if (sq_n_q >= sq_t) begin
        sq_n_q <= sq_n_q - sq_t;
        sq_r_q <= (sq_r_q >> 1) + sq_b_q;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_b_q <= sq_b_q >> 2;
    end
  end

  // Restoring divider: unit axis component, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= 33'({dv_abs[23:0], 7'd0});
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (div_t >= {1'b0, len}) begin
        rem_q <= div_t - {1'b0, len};
        q_q   <= {q_q[QBITS-2:0], 1'b1};
      end else begin
        rem_q <= div_t;
        q_q   <= {q_q[QBITS-2:0], 1'b0};
      end
    end
    if (cmd_i.div_wr)
      u_q[cmd_i.idx] <= clamp_one(q_s);
  end

  // CORDIC sine and cosine, one iteration per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.crd_init) begin
      cx_q   <= CRD_GAIN;
      cy_q   <= '0;
      cz_q   <= 34'($signed(ph_f));
      flip_q <= ph_flip;
    end else if (cmd_i.crd_step) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atn;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atn;
      end
    end
    if (cmd_i.crd_wr) begin
      c_q   <= c_new;
      s_q   <= s_new;
      omc_q <= 33'(ONE) - 33'(c_new);
    end
  end

  // Status and result
  assign sts_o.zero_axis = (m_q == '0);
  assign sts_o.norm_ok   = (m_q >= NORM_MIN);

  assign res_o.first_x    = f_q[0];
  assign res_o.first_y    = f_q[1];
  assign res_o.first_z    = f_q[2];
  assign res_o.second_x   = f_q[3];
  assign res_o.second_y   = f_q[4];
  assign res_o.second_z   = f_q[5];
  assign res_o.third_x    = f_q[6];
  assign res_o.third_y    = f_q[7];
  assign res_o.third_z    = f_q[8];
  assign res_o.axis_error = err_q;

endmodule

// File: rtl/orot_ctrl.sv
// Controller: sequences normalization, multiply program, root, divider and CORDIC.
module orot_ctrl import orot_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] opcode_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  st_e        st_q, st_d;
  logic [5:0] pc_q, pc_d;
  logic [4:0] k_q, k_d;
  logic [1:0] idx_q, idx_d;
  uop_t       cur_uop;
  logic       has_wb;

  assign cur_uop = uop_rom(pc_q);
  assign has_wb  = (cur_uop.wb != WB_NONE);

  // Next state and counters
  always_comb begin
    st_d  = st_q;
    pc_d  = pc_q;
    k_d   = k_q;
    idx_d = idx_q;
    unique case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (op_e'(opcode_i))
            OP_RESTORE, OP_IDENT: st_d = ST_DONE;
            default:              st_d = ST_CHECK;
          endcase
        end
      end
      ST_CHECK: st_d = sts_i.zero_axis ? ST_DONE : ST_NORM;
      ST_NORM: begin
        if (sts_i.norm_ok) begin
          st_d = ST_LDA;
          pc_d = '0;
        end
      end
      ST_LDA: st_d = ST_MUL;
      ST_MUL: st_d = ST_ACC;
      ST_ACC, ST_WB: begin
        if (st_q == ST_ACC && has_wb) begin
          st_d = ST_WB;
        end else if (pc_q == PC_SQ_LAST) begin
          st_d = ST_SQRT;
          k_d  = '0;
        end else if (pc_q == PC_LAST) begin
          st_d = ST_COMMIT;
        end else begin
          st_d = ST_LDA;
          pc_d = pc_q + 6'd1;
        end
      end
      ST_SQRT: begin
        if (k_q == 5'(SQRT_STEPS - 1)) begin
          st_d  = ST_DIVI;
          idx_d = '0;
        end else begin
          k_d = k_q + 5'd1;
        end
      end
      ST_DIVI: begin
        st_d = ST_DIV;
        k_d  = '0;
      end
      ST_DIV: begin
        if (k_q == 5'(QBITS - 1)) st_d = ST_DIVW;
        else k_d = k_q + 5'd1;
      end
      ST_DIVW: begin
        if (idx_q == 2'd2) begin
          st_d = ST_CRDI;
        end else begin
          st_d  = ST_DIVI;
          idx_d = idx_q + 2'd1;
        end
      end
      ST_CRDI: begin
        st_d = ST_CRD;
        k_d  = '0;
      end
      ST_CRD: begin
        if (k_q == 5'(CRD_STEPS - 1)) st_d = ST_CRDW;
        else k_d = k_q + 5'd1;
      end
      ST_CRDW: begin
        st_d = ST_LDA;
        pc_d = PC_ROT_FIRST;
      end
      ST_COMMIT: st_d = ST_DONE;
      ST_DONE:   st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // Command decode
  always_comb begin
    cmd_o     = '0;
    cmd_o.mac = MP_IDLE;
    cmd_o.pc  = pc_q;
    cmd_o.k   = k_q;
    cmd_o.idx = idx_q;
    unique case (st_q)
      ST_IDLE: begin
        cmd_o.latch    = start_i;
        cmd_o.save     = start_i && (op_e'(opcode_i) == OP_SAVE_ROT);
        cmd_o.restore  = start_i && (op_e'(opcode_i) == OP_RESTORE);
        cmd_o.identity = start_i && (op_e'(opcode_i) == OP_IDENT);
      end
      ST_CHECK:  cmd_o.set_err   = sts_i.zero_axis;
      ST_NORM:   cmd_o.norm_step = !sts_i.norm_ok;
      ST_LDA:    cmd_o.mac       = MP_LDA;
      ST_MUL:    cmd_o.mac       = MP_MUL;
      ST_ACC:    cmd_o.mac       = MP_ACC;
      ST_WB:     cmd_o.mac       = MP_WB;
      ST_SQRT:   cmd_o.sqrt_step = 1'b1;
      ST_DIVI:   cmd_o.div_init  = 1'b1;
      ST_DIV:    cmd_o.div_step  = 1'b1;
      ST_DIVW:   cmd_o.div_wr    = 1'b1;
      ST_CRDI:   cmd_o.crd_init  = 1'b1;
      ST_CRD:    cmd_o.crd_step  = 1'b1;
      ST_CRDW:   cmd_o.crd_wr    = 1'b1;
      ST_COMMIT: cmd_o.commit    = 1'b1;
      default:   ;
    endcase
  end

  assign busy_o = (st_q != ST_IDLE);
  assign done_o = (st_q == ST_DONE);

  // State and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      pc_q  <= '0;
      k_q   <= '0;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      pc_q  <= pc_d;
      k_q   <= k_d;
      idx_q <= idx_d;
    end
  end

  // Restore and identity go straight from idle to the result state
  a_fast_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE && start_i &&
     (op_e'(opcode_i) == OP_RESTORE || op_e'(opcode_i) == OP_IDENT)) |=> done_o)
    else $error("restore/identity did not complete next cycle");

  // A result is always followed by an idle cycle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("controller not idle after result");

  // Root finishes into the divider with the first axis component
  a_sqrt_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SQRT && k_q == 5'(SQRT_STEPS - 1)) |=> (st_q == ST_DIVI && idx_q == 2'd0))
    else $error("square root did not hand over to divider");

  // Multiply program ends only at its last entry
  a_commit_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_COMMIT) |-> (pc_q == PC_LAST))
    else $error("frame committed before program end");

endmodule

// File: dv/tb_orientation_frame_rotator_top.sv
// Testbench for the orientation frame rotator: random and directed beats checked against a predictor.
`timescale 1ns / 100ps

module tb_orientation_frame_rotator_top;
  import orot_pkg::*;

  localparam longint FX_ONE = 64'sd1 <<< FRAC_BITS;
  localparam int     DRAIN_CYCLES = 400;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  item_i;
  logic result_valid_o;
  out_t result_o;

  orientation_frame_rotator_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .result_valid_o(result_valid_o), .result_o(result_o)
  );

  // Predictor state
  longint pose[9];
  longint pose_saved[9];
  longint atan_lut[30];

  in_t    pending_items[$];
  out_t   expected_frames[$];
  int     mismatches;
  int     beats_sent;
  int     beats_checked;
  int     items_queued;
  int     zero_axis_count;
  bit     hold_off;
  bit     quiet_run;
  bit     beat_taken;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Math helpers, 64-bit signed with rounding shifts
  function automatic longint sat_one(input longint v);
    if (v > FX_ONE) return FX_ONE;
    if (v < -FX_ONE) return -FX_ONE;
    return v;
  endfunction

  function automatic longint rnd_shift(input longint v, input int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return rnd_shift(a * b, FRAC_BITS);
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void sine_cosine(input logic [31:0] ph, output longint s,
                                      output longint c);
    bit     flip;
    longint x, y, z, nx;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (32'(ph + QUARTER) >= HALF_TURN) begin
      ph = ph ^ HALF_TURN;
      flip = 1'b1;
    end
    z = longint'($signed(ph));
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_lut[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = sat_one(rnd_shift(x, 30 - FRAC_BITS));
    s = sat_one(rnd_shift(y, 30 - FRAC_BITS));
  endfunction

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint r[3]);
    r[0] = rnd_shift(a[1] * b[2] - a[2] * b[1], FRAC_BITS);
    r[1] = rnd_shift(a[2] * b[0] - a[0] * b[2], FRAC_BITS);
    r[2] = rnd_shift(a[0] * b[1] - a[1] * b[0], FRAC_BITS);
  endfunction

  function automatic void rodrigues_vec(input longint v[3], input longint u[3],
                                        input longint s, input longint c,
                                        output longint r[3]);
    longint d, omc, w[3];
    d = rnd_shift(v[0] * u[0] + v[1] * u[1] + v[2] * u[2], FRAC_BITS);
    omc = FX_ONE - c;
    cross_prod(u, v, w);
    for (int i = 0; i < 3; i++)
      r[i] = sat_one(qmul(v[i], c) + qmul(qmul(u[i], d), omc) + qmul(w[i], s));
  endfunction

  // Rotates the predicted pose; returns 1 on a zero axis
  function automatic bit rotate_pose(input in_t it);
    longint v[3], u[3], t[3], a[3], b[3], na[3], nb[3], nc[3];
    longint m, n2, s, c;
    longint unsigned len;
    int sh;
    m = 0;
    n2 = 0;
    sh = 0;
    v[0] = it.axis_x;
    v[1] = it.axis_y;
    v[2] = it.axis_z;
    for (int i = 0; i < 3; i++) begin
      t[i] = (v[i] < 0) ? -v[i] : v[i];
      if (t[i] > m) m = t[i];
    end
    if (m == 0) return 1'b1;
    while ((m <<< sh) < (64'sd1 <<< 22)) sh++;
    for (int i = 0; i < 3; i++) begin
      v[i] = v[i] <<< sh;
      n2 += v[i] * v[i];
    end
    len = int_sqrt(longint'(n2) << 16);
    for (int i = 0; i < 3; i++)
      u[i] = sat_one((v[i] * (64'sd1 <<< (FRAC_BITS + 8))) / longint'(len));
    sine_cosine(it.turn_angle & ANGLE_MASK, s, c);
    for (int i = 0; i < 3; i++) begin
      a[i] = pose[i];
      b[i] = pose[3 + i];
    end
    rodrigues_vec(a, u, s, c, na);
    rodrigues_vec(b, u, s, c, nb);
    cross_prod(na, nb, nc);
    for (int i = 0; i < 3; i++) begin
      pose[i] = na[i];
      pose[3 + i] = nb[i];
      pose[6 + i] = sat_one(nc[i]);
    end
    return 1'b0;
  endfunction

  function automatic out_t predict_frame(input in_t it);
    out_t o;
    bit   err;
    err = 1'b0;
    case (op_e'(it.opcode))
      OP_SAVE_ROT: begin
        pose_saved = pose;
        err = rotate_pose(it);
      end
      OP_RESTORE: pose = pose_saved;
      OP_IDENT: for (int i = 0; i < 9; i++) pose[i] = (i % 4 == 0) ? FX_ONE : 0;
      default: err = rotate_pose(it);
    endcase
    o.first_x = 32'(pose[0]);
    o.first_y = 32'(pose[1]);
    o.first_z = 32'(pose[2]);
    o.second_x = 32'(pose[3]);
    o.second_y = 32'(pose[4]);
    o.second_z = 32'(pose[5]);
    o.third_x = 32'(pose[6]);
    o.third_y = 32'(pose[7]);
    o.third_z = 32'(pose[8]);
    o.axis_error = err;
    return o;
  endfunction

  function automatic in_t make_item(input op_e op, input int ax, input int ay, input int az,
                                    input logic [31:0] ang);
    in_t it;
    it.opcode = op;
    it.axis_x = 24'(ax);
    it.axis_y = 24'(ay);
    it.axis_z = 24'(az);
    it.turn_angle = ang;
    return it;
  endfunction

  // Queue one beat for the driver
  task automatic queue_item(input in_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Axis component: mixes full range, small values, extremes and zero
  function automatic int rand_comp();
    case ($urandom_range(9))
      0: return 0;
      1: return -8388608;
      2: return 8388607;
      3, 4: return int'($urandom_range(64)) - 32;
      default: return int'($signed(24'($urandom)));
    endcase
  endfunction

  // Driver: presents beats at the falling edge, holds a beat until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || beat_taken) begin
        if (pending_items.size() != 0 && !hold_off &&
            (quiet_run || $urandom_range(99) >= 11)) begin
          item_i <= pending_items.pop_front();
          start  <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Handshake bookkeeping
  always @(posedge clk_i) begin
    beat_taken <= rst_ni && start && !busy;
    if (rst_ni && start && !busy) begin
      expected_frames.push_back(predict_frame(item_i));
      beats_sent++;
    end
  end

  // Monitor: compares each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    out_t exp_o;
    if (rst_ni && result_valid_o) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", result_o);
      end else begin
        exp_o = expected_frames.pop_front();
        beats_checked++;
        if (exp_o.axis_error) zero_axis_count++;
        if (result_o !== exp_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on beat %0d\n  exp %p\n  got %p", beats_checked, exp_o, result_o);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    op_e op;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    beat_taken = 1'b0;
    hold_off = 1'b0;
    quiet_run = 1'b0;
    mismatches = 0;
    beats_sent = 0;
    beats_checked = 0;
    items_queued = 0;
    zero_axis_count = 0;
    for (int i = 0; i < 30; i++) atan_lut[i] = atan_turn(5'(i));
    for (int i = 0; i < 9; i++) begin
      pose[i] = (i % 4 == 0) ? FX_ONE : 0;
      pose_saved[i] = pose[i];
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every opcode, zero axis, extreme axes and angles
    queue_item(make_item(OP_RESTORE, 0, 0, 0, 32'h0));
    queue_item(make_item(OP_ROT, 0, 0, 0, 32'h1234_5678));
    queue_item(make_item(OP_SAVE_ROT, 0, 0, 0, 32'hFFFF_FFFF));
    queue_item(make_item(OP_ROT, 0, 0, 1, 32'h4000_0000));
    queue_item(make_item(OP_ROT, 8388607, 0, 0, 32'h8000_0000));
    queue_item(make_item(OP_SAVE_ROT, 0, -8388608, 0, 32'hC000_0000));
    queue_item(make_item(OP_ROT, -8388608, -8388608, -8388608, 32'hFFFF_FFFF));
    queue_item(make_item(OP_ROT, 8388607, 8388607, 8388607, 32'h0));
    queue_item(make_item(OP_ROT, 1, -1, 1, 32'h3FFF_FFFF));
    queue_item(make_item(OP_ROT, -1, 1, -1, 32'h7FFF_FFFF));
    queue_item(make_item(OP_RESTORE, 5, 5, 5, 32'h1));
    queue_item(make_item(OP_ROT, 3, 4, 0, 32'hBFFF_FFFF));
    queue_item(make_item(OP_IDENT, -1, -1, -1, 32'hFFFF_FFFF));
    queue_item(make_item(OP_SAVE_ROT, 8388607, -8388608, 1, 32'h2000_0000));
    queue_item(make_item(OP_RESTORE, 0, 0, 0, 32'h0));
    wait (pending_items.size() == 0);

    // Sender pause until every result is back
    hold_off = 1'b1;
    wait (beats_sent == items_queued);
    wait (expected_frames.size() == 0);
    repeat (5) @(posedge clk_i);
    hold_off = 1'b0;

    // Random: mostly rotate chains, some save/restore/identity
    for (int n = 0; n < 700; n++) begin
      case ($urandom_range(19))
        0: op = OP_IDENT;
        1, 2: op = OP_RESTORE;
        3, 4, 5: op = OP_SAVE_ROT;
        default: op = OP_ROT;
      endcase
      queue_item(make_item(op, rand_comp(), rand_comp(), rand_comp(), $urandom));
      if (n == 300) quiet_run = 1'b1;
      if (n == 400) quiet_run = 1'b0;
      wait (pending_items.size() < 4);
    end
    wait (beats_sent == items_queued);
    wait (expected_frames.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d beats on all four opcodes, %0d with a zero axis",
             beats_checked, zero_axis_count);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_frames.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", expected_frames.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
